// ===== sv/rfp_pkg.sv =====
`timescale 1ns / 1ps
// rfp_pkg: shared types and constants for the ring fifo with indexed peek
// depends on nothing; used by every other file of the block but rfp_ram

package rfp_pkg;

    localparam int DEPTH     = 64;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH) + 1;

    // apb register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_ACTIVE_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_STATUS = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic load_out;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/rfp_ifs.sv =====
`timescale 1ns / 1ps
// rfp_req_if / rfp_rsp_if: valid-ready channels for requests and results
// depends on rfp_pkg

interface rfp_req_if;
    logic                           valid;
    logic                           ready;
    rfp_pkg::t_action               action;
    logic [rfp_pkg::DATA_BITS-1:0]  push_data;
    logic [rfp_pkg::IDX_W-1:0]      offset;

    modport source (output valid, action, push_data, offset, input ready);
    modport sink   (input valid, action, push_data, offset, output ready);
endinterface

interface rfp_rsp_if;
    logic                           valid;
    logic                           ready;
    rfp_pkg::t_status               status;
    logic [rfp_pkg::DATA_BITS-1:0]  read_data;
    logic [rfp_pkg::CNT_W-1:0]      fill_count;
    logic [rfp_pkg::CNT_W-1:0]      free_slots;
    logic                           not_empty;

    modport source (output valid, status, read_data, fill_count, free_slots, not_empty,
                    input ready);
    modport sink   (input valid, status, read_data, fill_count, free_slots, not_empty,
                    output ready);
endinterface

// ===== sv/ring_fifo_with_indexed_peek.sv =====
`timescale 1ns / 1ps
// a request beat is taken in S_IDLE, its slot ram read is registered on acceptance and held
//   while the controller waits in S_READ, and the result register is loaded once it is free;
//   no new request is taken until then, so a stalled result holds off only the following request
// reset: synchronous active low; pointers and fill level clear, active length goes to 64,
//   the slot ram is not cleared (data from an unwritten slot is never returned)
// depends on rfp_pkg, rfp_ifs, rfp_ram, rfp_ctrl, rfp_datapath

module ring_fifo_with_indexed_peek (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rfp_req_if.sink                        i_req,
    rfp_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    rfp_pkg::t_ctl_cmd         w_cmd;
    rfp_pkg::t_dp_sts          w_sts;
    logic                      w_cfg_we;
    logic                      w_reg_sel;
    logic [rfp_pkg::CNT_W-1:0] w_len;

    // apb: zero wait states, register 0 (active length) at byte address 0
    // a length write also empties the fifo; stored words stay
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[rfp_pkg::APB_ADDR_W-1] == rfp_pkg::REG_ACTIVE_LENGTH);
    assign w_cfg_we  = psel && penable && pwrite && w_reg_sel;
    assign prdata    = w_reg_sel ? rfp_pkg::APB_DATA_W'(w_len) : '0;

    // controller: takes a request beat, then waits for the result register
    rfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: status decision and pointer update on accept, ram read in flight,
    // result register loaded once it is free
    rfp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_wdata (pwdata),
        .o_len       (w_len),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

`ifndef SYNTH
    // not_empty tracks the reported fill count
    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.not_empty == (o_rsp.fill_count != '0)))
        else $error("not_empty disagrees with fill_count");

    // refused requests return zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != rfp_pkg::ST_OK)) |-> (o_rsp.read_data == '0))
        else $error("refused request returned data");

    // result register is loaded only when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("result register overwritten");

    // one request in flight: no accept on the cycle right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> !w_cmd.accept)
        else $error("second request accepted while busy");
`endif

endmodule

// ===== sv/rfp_ram.sv =====
`timescale 1ns / 1ps
// rfp_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module rfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rfp_ctrl.sv =====
`timescale 1ns / 1ps
// rfp_ctrl: request sequencer, one beat in flight at a time
// depends on rfp_pkg

module rfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rfp_pkg::t_dp_sts  i_sts,
    output rfp_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   w_accept;
    logic   w_load;

    assign w_accept = r_in_ready && i_in_valid;
    assign w_load   = (r_state == S_READ) && i_sts.out_free;

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state    = S_READ;
                    n_in_ready = 1'b0;
                end
            end
            S_READ: begin
                // wait for the output register to free up
                if (w_load) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_cmd.in_ready = r_in_ready;
    assign o_cmd.accept   = w_accept;
    assign o_cmd.load_out = w_load;

endmodule

// ===== sv/rfp_datapath.sv =====
`timescale 1ns / 1ps
// rfp_datapath: pointers, fill level, length register, slot ram and result register
// depends on rfp_pkg, rfp_ifs, rfp_ram

module rfp_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rfp_req_if.sink                           i_req,
    rfp_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [rfp_pkg::APB_DATA_W-1:0]    i_cfg_wdata,
    output logic [rfp_pkg::CNT_W-1:0]         o_len,
    input  rfp_pkg::t_ctl_cmd                 i_cmd,
    output rfp_pkg::t_dp_sts                  o_sts
);

    localparam int IDX_W = rfp_pkg::IDX_W;
    localparam int CNT_W = rfp_pkg::CNT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(rfp_pkg::DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [CNT_W-1:0] r_len, r_fill;
    logic [IDX_W-1:0] r_rd_idx, r_wr_idx;

    rfp_pkg::t_status r_pend_status, w_status;
    logic             r_pend_use_rd, w_use_rd;

    logic                          r_out_valid;
    rfp_pkg::t_status              r_out_status;
    logic [rfp_pkg::DATA_BITS-1:0] r_out_data;
    logic [CNT_W-1:0]              r_out_fill, r_out_free;

    logic                          w_full, w_empty, w_off_ok;
    logic [CNT_W-1:0]              w_pos_sum, w_pos_wrap, w_len_in, n_len;
    logic [IDX_W-1:0]              w_raddr;
    logic                          w_we;
    logic [rfp_pkg::DATA_BITS-1:0] w_rdata;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] n;
        n = {1'b0, idx} + ONE_C;
        return (n >= len) ? '0 : n[IDX_W-1:0];
    endfunction

    // length write: only the low 7 bits count; zero reads as one, anything above depth as depth
    assign w_len_in = i_cfg_wdata[CNT_W-1:0];
    assign n_len = (w_len_in == '0)     ? ONE_C :
                   (w_len_in > DEPTH_C) ? DEPTH_C : w_len_in;

    assign w_full    = (r_fill >= r_len);
    assign w_empty   = (r_fill == '0);
    assign w_off_ok  = (CNT_W'(i_req.offset) < r_fill);
    assign w_pos_sum = {1'b0, r_rd_idx} + CNT_W'(i_req.offset);
    assign w_pos_wrap = (w_pos_sum >= r_len) ? (w_pos_sum - r_len) : w_pos_sum;

    always_comb begin
        w_status = rfp_pkg::ST_OK;
        w_use_rd = 1'b0;
        w_we     = 1'b0;
        w_raddr  = r_rd_idx;
        unique case (i_req.action)
            rfp_pkg::ACT_PUSH: begin
                if (w_full) begin
                    w_status = rfp_pkg::ST_FULL;
                end else begin
                    w_we = i_cmd.accept;
                end
            end
            rfp_pkg::ACT_POP: begin
                if (w_empty) begin
                    w_status = rfp_pkg::ST_EMPTY;
                end else begin
                    w_use_rd = 1'b1;
                end
            end
            rfp_pkg::ACT_PEEK: begin
                w_raddr = w_pos_wrap[IDX_W-1:0];
                if (!w_off_ok) begin
                    w_status = rfp_pkg::ST_RANGE;
                end else begin
                    w_use_rd = 1'b1;
                end
            end
            rfp_pkg::ACT_STATUS: begin
                w_status = rfp_pkg::ST_OK;
            end
            default: begin
                w_status = rfp_pkg::ST_OK;
            end
        endcase
    end

    rfp_ram #(
        .WIDTH (rfp_pkg::DATA_BITS),
        .DEPTH (rfp_pkg::DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_idx),
        .i_wdata (i_req.push_data),
        .i_re    (i_cmd.accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // pointer and fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= DEPTH_C;
            r_fill   <= '0;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
        end else if (i_cfg_we) begin
            r_len    <= n_len;
            r_fill   <= '0;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
        end else if (i_cmd.accept && (w_status == rfp_pkg::ST_OK)) begin
            if (i_req.action == rfp_pkg::ACT_PUSH) begin
                r_wr_idx <= wrap_next(r_wr_idx, r_len);
                r_fill   <= r_fill + ONE_C;
            end else if (i_req.action == rfp_pkg::ACT_POP) begin
                r_rd_idx <= wrap_next(r_rd_idx, r_len);
                r_fill   <= r_fill - ONE_C;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_status <= w_status;
            r_pend_use_rd <= w_use_rd;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_pend_status;
            r_out_data   <= r_pend_use_rd ? w_rdata : '0;
            r_out_fill   <= r_fill;
            r_out_free   <= r_len - r_fill;
        end
    end

    assign o_sts.out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready      = i_cmd.in_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_data  = r_out_data;
    assign o_rsp.fill_count = r_out_fill;
    assign o_rsp.free_slots = r_out_free;
    assign o_rsp.not_empty  = (r_out_fill != '0);

    assign o_len = r_len;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for ring_fifo_with_indexed_peek, with directed and random
// request traffic, random idle and stall, and an in-bench fifo mirror that predicts results
// depends on rfp_pkg, rfp_ifs and the ring_fifo_with_indexed_peek rtl

module tb;
    import rfp_pkg::*;

    // cycles without any accepted beat before the run is declared hung
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    // room for predicted result beats not yet taken; at most two are ever in flight
    localparam int unsigned EXP_DEPTH      = 16;

    // one expected result beat, field for field as on the result channel
    typedef struct packed {
        t_status              status;
        logic [DATA_BITS-1:0] read_data;
        logic [CNT_W-1:0]     fill_count;
        logic [CNT_W-1:0]     free_slots;
        logic                 not_empty;
    } t_fifo_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // apb side
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rfp_req_if req_chan ();
    rfp_rsp_if rsp_chan ();

    ring_fifo_with_indexed_peek DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_chan),
        .o_rsp   (rsp_chan),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // fifo mirror: slot contents, pointers, fill level and active length as the block sees them
    logic [DATA_BITS-1:0] mirror_slots [DEPTH];
    int unsigned          mirror_rd   = 0;
    int unsigned          mirror_wr   = 0;
    int unsigned          mirror_fill = 0;
    int unsigned          mirror_len  = DEPTH;

    // results predicted for accepted request beats, oldest first, as a ring of entries
    t_fifo_result exp_mem [EXP_DEPTH];
    int unsigned  exp_wr = 0;
    int unsigned  exp_rd = 0;

    int unsigned mismatch_count  = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned rsp_hold_cycles = 0;

    // advance the mirror by one request and return the result it must produce
    function automatic t_fifo_result predict_fifo_result(t_action act,
                                                         logic [DATA_BITS-1:0] data,
                                                         logic [IDX_W-1:0] off);
        t_fifo_result res;
        int unsigned  pos;
        res.status    = ST_OK;
        res.read_data = '0;
        case (act)
            ACT_PUSH: begin
                if (mirror_fill >= mirror_len) begin
                    res.status = ST_FULL;
                end else begin
                    mirror_slots[mirror_wr] = data;
                    mirror_wr = (mirror_wr + 1 >= mirror_len) ? 0 : mirror_wr + 1;
                    mirror_fill++;
                end
            end
            ACT_POP: begin
                if (mirror_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_data = mirror_slots[mirror_rd];
                    mirror_rd = (mirror_rd + 1 >= mirror_len) ? 0 : mirror_rd + 1;
                    mirror_fill--;
                end
            end
            ACT_PEEK: begin
                if (off >= mirror_fill) begin
                    res.status = ST_RANGE;
                end else begin
                    // offset counted from the front, wrapping at the active length
                    pos = mirror_rd + off;
                    if (pos >= mirror_len) pos -= mirror_len;
                    res.read_data = mirror_slots[pos];
                end
            end
            default: begin
                // status only: nothing moves
            end
        endcase
        res.fill_count = CNT_W'(mirror_fill);
        res.free_slots = CNT_W'(mirror_len - mirror_fill);
        res.not_empty  = (mirror_fill != 0);
        return res;
    endfunction

    // offer one request beat (after a random idle gap) and hold it until accepted
    task automatic send_request(t_action act, logic [DATA_BITS-1:0] data,
                                logic [IDX_W-1:0] off);
        while ($urandom_range(99) < send_idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_chan.valid     <= 1'b1;
        req_chan.action    <= act;
        req_chan.push_data <= data;
        req_chan.offset    <= off;
        do @(posedge i_clk); while (!req_chan.ready);
        exp_mem[exp_wr % EXP_DEPTH] = predict_fifo_result(act, data, off);
        exp_wr++;
    endtask

    // random request: push with the given bias, otherwise pop, peek or status
    task automatic send_random_request(int unsigned push_bias);
        t_action          act;
        int unsigned      pick;
        logic [IDX_W-1:0] off;
        pick = $urandom_range(99);
        if (pick < push_bias)
            act = ACT_PUSH;
        else begin
            pick = $urandom_range(9);
            act  = (pick < 5) ? ACT_POP : (pick < 9) ? ACT_PEEK : ACT_STATUS;
        end
        // peeks mostly land inside the held entries, the rest anywhere
        if (act == ACT_PEEK && mirror_fill != 0 && $urandom_range(3) != 0)
            off = IDX_W'($urandom_range(mirror_fill - 1));
        else
            off = IDX_W'($urandom_range(DEPTH - 1));
        send_request(act, DATA_BITS'($urandom), off);
    endtask

    // drop valid and wait until every predicted result beat has been taken
    task automatic wait_until_drained();
        if (exp_wr != exp_rd) begin
            req_chan.valid <= 1'b0;
            while (exp_wr != exp_rd) @(posedge i_clk);
        end
    endtask

    // apb write of active_length: setup cycle, then access cycle
    task automatic write_active_length(logic [APB_DATA_W-1:0] word);
        int unsigned len;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_ACTIVE_LENGTH, 2'b00});
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the low 7 bits count; zero means one slot, anything above the depth means all
        len = word[6:0];
        if (len < 1) len = 1;
        if (len > DEPTH) len = DEPTH;
        mirror_len  = len;
        mirror_rd   = 0;
        mirror_wr   = 0;
        mirror_fill = 0;
    endtask

    // fresh fifo at the reset length: refusals on empty and a status-only request
    task automatic test_empty_fifo();
        send_request(ACT_POP, '1, '0);
        send_request(ACT_PEEK, '0, '0);
        send_request(ACT_PEEK, 32'h5A5A_5A5A, '1);
        send_request(ACT_STATUS, '1, '1);
        wait_until_drained();
    endtask

    // extreme words in and out, peeks at every held position and one past the end
    task automatic test_push_peek_pop();
        send_request(ACT_PUSH, '0, '0);
        send_request(ACT_PUSH, '1, '1);
        send_request(ACT_PUSH, 32'hA5A5_5A5A, '0);
        send_request(ACT_PEEK, '0, 6'd0);
        send_request(ACT_PEEK, '0, 6'd1);
        send_request(ACT_PEEK, '0, 6'd2);
        send_request(ACT_PEEK, '0, 6'd3);
        send_request(ACT_POP, '0, '0);
        send_request(ACT_POP, '0, '0);
        send_request(ACT_POP, '0, '0);
        send_request(ACT_STATUS, '0, '0);
        wait_until_drained();
    endtask

    // two-slot fifo: full refusal, pointer wrap and a peek across the wrap
    task automatic test_wrap_and_full();
        write_active_length(32'd2);
        send_request(ACT_PUSH, 32'h1111_1111, '0);
        send_request(ACT_PUSH, 32'h2222_2222, '0);
        send_request(ACT_PUSH, 32'h3333_3333, '0);
        send_request(ACT_POP, '0, '0);
        send_request(ACT_PUSH, 32'h4444_4444, '0);
        send_request(ACT_PEEK, '0, 6'd1);
        send_request(ACT_POP, '0, '0);
        send_request(ACT_POP, '0, '0);
        send_request(ACT_POP, '0, '0);
        wait_until_drained();
    endtask

    // length zero taken as one, oversized length taken as the depth, and a write empties
    task automatic test_length_clamp();
        write_active_length(32'd0);
        send_request(ACT_PUSH, 32'hDEAD_BEEF, '0);
        send_request(ACT_PUSH, 32'hCAFE_F00D, '0);
        wait_until_drained();
        write_active_length(32'hFFFF_FF7F);
        send_request(ACT_STATUS, '0, '0);
        wait_until_drained();
    endtask

    // receiver holds off long while requests keep coming, so the input side stalls
    task automatic test_backpressure();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        rsp_hold_cycles = 80;
        repeat (30) send_random_request(70);
        // sender pauses until every result is back
        wait_until_drained();
    endtask

    // random traffic under one idle setting: new length per round, push-heavy,
    // balanced and pop-heavy bursts so both full and empty get reached
    task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                       int unsigned stall_pct);
        int unsigned      sent;
        int unsigned      chunk;
        int unsigned      push_bias;
        logic [6:0]       len_code;
        logic [APB_DATA_W-1:0] word;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items) begin
            wait_until_drained();
            case ($urandom_range(9))
                0:       len_code = 7'd0;
                1:       len_code = 7'd1;
                2:       len_code = 7'd2;
                3:       len_code = 7'(DEPTH);
                4:       len_code = 7'($urandom_range(DEPTH + 1, 127));
                default: len_code = 7'($urandom_range(1, DEPTH));
            endcase
            word = {APB_DATA_W{1'b0}};
            if ($urandom_range(1)) word = $urandom;
            word[6:0] = len_code;
            write_active_length(word);
            repeat ($urandom_range(1, 3)) begin
                chunk = $urandom_range(4, 2 * mirror_len + 6);
                case ($urandom_range(2))
                    0:       push_bias = 90;
                    1:       push_bias = 55;
                    default: push_bias = 20;
                endcase
                repeat (chunk) begin
                    if (sent < n_items) begin
                        send_random_request(push_bias);
                        sent++;
                    end
                end
            end
        end
        wait_until_drained();
    endtask

    // result receiver: random stalls, plus a counted hold-off when one is asked for
    initial begin
        rsp_chan.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_cycles != 0) begin
                rsp_hold_cycles--;
                rsp_chan.ready <= 1'b0;
            end else begin
                rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker and watchdog; samples pre-edge values at each rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
                if (exp_wr == exp_rd) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result beat: st=%0d rd=%h fill=%0d free=%0d ne=%0b",
                                 rsp_chan.status, rsp_chan.read_data, rsp_chan.fill_count,
                                 rsp_chan.free_slots, rsp_chan.not_empty);
                end else begin
                    t_fifo_result want;
                    want = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (rsp_chan.status     !== want.status     ||
                        rsp_chan.read_data  !== want.read_data  ||
                        rsp_chan.fill_count !== want.fill_count ||
                        rsp_chan.free_slots !== want.free_slots ||
                        rsp_chan.not_empty  !== want.not_empty) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("result mismatch: expected st=%0d rd=%h fill=%0d free=%0d ne=%0b",
                                     want.status, want.read_data, want.fill_count,
                                     want.free_slots, want.not_empty);
                            $display("                 got      st=%0d rd=%h fill=%0d free=%0d ne=%0b",
                                     rsp_chan.status, rsp_chan.read_data, rsp_chan.fill_count,
                                     rsp_chan.free_slots, rsp_chan.not_empty);
                        end
                    end
                end
            end
            // any beat on either channel counts as progress
            if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        req_chan.valid     = 1'b0;
        req_chan.action    = ACT_STATUS;
        req_chan.push_data = '0;
        req_chan.offset    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_fifo();
        test_push_peek_pop();
        test_wrap_and_full();
        test_length_clamp();
        test_backpressure();
        // idle settings: none, sender only, receiver only, both
        test_random_traffic(200, 0, 0);
        test_random_traffic(200, 51, 0);
        test_random_traffic(200, 0, 51);
        test_random_traffic(200, 32, 32);

        wait_until_drained();
        // let any stray beat show up
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
